// ===== hdl/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Field widths of the word channels
  localparam int KIND_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int POS_W     = 11;
  localparam int WORD_W    = 16;
  localparam int COLOR_W   = 4;
  localparam int CFG_IDX_W = 1;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BACK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORE = 1'd1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  // Colour reset values and the cell value the screen holds after reset
  localparam logic [COLOR_W-1:0] BACK_RESET = 4'h0;
  localparam logic [COLOR_W-1:0] FORE_RESET = 4'hF;
  localparam logic [WORD_W-1:0]  RESET_CELL = 16'h0F00;

endpackage

`default_nettype wire

// ===== hdl/tcw_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tcw_in_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [CHAR_W-1:0]   char_code;
  logic [IDX_W-1:0]    cell_index;

  modport source (output valid, kind, char_code, cell_index, input ready);
  modport sink   (input valid, kind, char_code, cell_index, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    cursor_pos;
  logic [WORD_W-1:0]   cell_word;
  logic                scrolled;

  modport source (output valid, cursor_pos, cell_word, scrolled, input ready);
  modport sink   (input valid, cursor_pos, cell_word, scrolled, output ready);
endinterface

`default_nettype wire

// ===== hdl/tcw_cell_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port screen RAM, one write and one registered read per cycle.
module tcw_cell_ram #(
  parameter int Depth = 2000,
  parameter int Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/text_console_writer.sv =====
// Order: put and read give their result from ST_REPLY / ST_READ through the
//   output register; clear first sweeps every cell, a put that scrolls first
//   does one RAM pass (copy up a row, blank the bottom row).
// Throughput: a new word is taken only in ST_IDLE, with the output register free.
// Reset: async, active low; then a clearing pass writes 0x0F00 into every cell,
//   with item_i.ready low until it ends.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tcw_in_if.sink               item_i,
  tcw_out_if.source            result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COLOR_W-1:0]   cfg_data_i
);

  // Geometry
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);            // RAM address
  localparam int RW    = $clog2(ROWS + 1);         // row may sit one past the end
  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = $clog2((ROWS + 1) * COLUMNS);
  localparam int XW    = ((AW > IDX_W) ? AW : IDX_W) + 1;

  localparam logic [AW-1:0] LAST_CELL      = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_ROW_START = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STRIDE     = AW'(COLUMNS);
  localparam logic [CW-1:0] COL_MAX        = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST       = RW'(ROWS - 1);
  localparam logic [RW-1:0] ROW_OVER       = RW'(ROWS);

  // Sequencer: FILL sweeps a constant into a run of cells (clear, reset,
  // blank bottom row), COPY moves the screen up one row.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_REPLY = 5'b00100,
    ST_COPY  = 5'b01000,
    ST_FILL  = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [RW-1:0]      row_q, row_d;
  logic [CW-1:0]      col_q, col_d;
  logic [COLOR_W-1:0] back_q, back_d;
  logic [COLOR_W-1:0] fore_q, fore_d;
  logic [AW-1:0]      swp_q, swp_d;        // sweep / copy source address
  logic [WORD_W-1:0]  fill_val_q, fill_val_d;
  logic               reply_q, reply_d;    // sweep ends with a result word
  logic               scr_q, scr_d;
  logic               cp_v_q, cp_v_d;      // copy read in flight
  logic [AW-1:0]      cp_dst_q, cp_dst_d;
  logic               rd_oob_q, rd_oob_d;
  logic               out_v_q, out_v_d;
  logic [POS_W-1:0]   out_pos_q, out_pos_d;
  logic [WORD_W-1:0]  out_word_q, out_word_d;
  logic               out_scr_q, out_scr_d;

  logic [7:0]         attr;
  logic [PW-1:0]      pos;
  logic               in_ready;
  logic               accept;

  // Put-character next cursor
  logic [RW-1:0]      row_n;
  logic [CW-1:0]      col_n;
  logic               pw_en;
  logic [AW-1:0]      pw_addr;
  logic [WORD_W-1:0]  pw_data;
  logic [2:0]         tab_step;
  logic [CW:0]        tab_sum;

  // Read range check
  logic [XW-1:0]      idx_x;
  logic               idx_ok;

  // RAM ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  // Result load
  logic               ld;
  logic [WORD_W-1:0]  ld_word;
  logic               ld_scr;

  assign attr     = {back_q, fore_q};
  assign pos      = PW'(row_q) * PW'(COLUMNS) + PW'(col_q);
  // Output register parts the sides: a word may still wait while we accept.
  assign in_ready = (state_q == ST_IDLE) && (!out_v_q || result_o.ready);
  assign accept   = item_i.valid && in_ready;

  assign item_i.ready        = in_ready;
  assign result_o.valid      = out_v_q;
  assign result_o.cursor_pos = out_pos_q;
  assign result_o.cell_word  = out_word_q;
  assign result_o.scrolled   = out_scr_q;

  assign idx_x  = XW'(item_i.cell_index);
  assign idx_ok = idx_x < XW'(CELLS);

  // Cursor move for a put
  always_comb begin
    row_n    = row_q;
    col_n    = col_q;
    pw_en    = 1'b0;
    pw_addr  = AW'(pos);
    pw_data  = {attr, item_i.char_code};
    tab_step = 3'd4 - {1'b0, pos[1:0]};
    tab_sum  = (CW + 1)'(col_q) + (CW + 1)'(tab_step);
    case (item_i.char_code)
      CH_NEWLINE: begin
        row_n = row_q + RW'(1);
        col_n = '0;
      end
      CH_RETURN: begin
        col_n = '0;
      end
      CH_TAB: begin
        if (tab_sum >= (CW + 1)'(COLUMNS)) begin
          col_n = CW'(tab_sum - (CW + 1)'(COLUMNS));
          row_n = row_q + RW'(1);
        end else begin
          col_n = CW'(tab_sum);
        end
      end
      CH_BACKSPACE: begin
        // clamped at the home position
        if (pos != '0) begin
          if (col_q == '0) begin
            row_n = row_q - RW'(1);
            col_n = COL_MAX;
          end else begin
            col_n = col_q - CW'(1);
          end
          pw_en   = 1'b1;
          pw_addr = AW'(pos - PW'(1));
          pw_data = {attr, CH_SPACE};
        end
      end
      default: begin
        // printable codes stored, other controls ignored
        if (item_i.char_code >= CH_SPACE) begin
          pw_en = 1'b1;
          if (col_q == COL_MAX) begin
            col_n = '0;
            row_n = row_q + RW'(1);
          end else begin
            col_n = col_q + CW'(1);
          end
        end
      end
    endcase
  end

  // RAM port muxing; copy write-back has the write port over the sweep
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = swp_q;
    ram_wdata = fill_val_q;
    if (accept && (item_i.kind == KIND_PUT) && pw_en) begin
      ram_we    = 1'b1;
      ram_waddr = pw_addr;
      ram_wdata = pw_data;
    end else if (cp_v_q) begin
      ram_we    = 1'b1;
      ram_waddr = cp_dst_q;
      ram_wdata = ram_rdata;
    end else if (state_q == ST_FILL) begin
      ram_we    = 1'b1;
    end
    ram_raddr = (state_q == ST_COPY) ? swp_q : AW'(idx_x);
  end

  tcw_cell_ram #(
    .Depth (CELLS),
    .Width (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer and registers
  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    back_d     = back_q;
    fore_d     = fore_q;
    swp_d      = swp_q;
    fill_val_d = fill_val_q;
    reply_d    = reply_q;
    scr_d      = scr_q;
    cp_v_d     = 1'b0;
    cp_dst_d   = cp_dst_q;
    rd_oob_d   = rd_oob_q;
    out_v_d    = out_v_q && !result_o.ready;
    out_pos_d  = out_pos_q;
    out_word_d = out_word_q;
    out_scr_d  = out_scr_q;
    ld         = 1'b0;
    ld_word    = '0;
    ld_scr     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (item_i.kind)
            KIND_PUT: begin
              row_d = row_n;
              col_d = col_n;
              if (row_n == ROW_OVER) begin
                // ran off the bottom: shift up, blank the last row
                row_d      = ROW_LAST;
                swp_d      = ROW_STRIDE;
                fill_val_d = {attr, CH_SPACE};
                reply_d    = 1'b1;
                scr_d      = 1'b1;
                state_d    = ST_COPY;
              end else begin
                state_d = ST_REPLY;
              end
            end
            KIND_READ: begin
              rd_oob_d = !idx_ok;
              state_d  = ST_READ;
            end
            KIND_CLEAR: begin
              row_d      = '0;
              col_d      = '0;
              swp_d      = '0;
              fill_val_d = {attr, CH_NUL};
              reply_d    = 1'b1;
              scr_d      = 1'b0;
              state_d    = ST_FILL;
            end
            default: begin
              state_d = ST_REPLY;
            end
          endcase
        end
      end
      ST_READ: begin
        ld      = 1'b1;
        ld_word = rd_oob_q ? '0 : ram_rdata;
        state_d = ST_IDLE;
      end
      ST_REPLY: begin
        ld      = 1'b1;
        state_d = ST_IDLE;
      end
      ST_COPY: begin
        cp_v_d   = 1'b1;
        cp_dst_d = swp_q - ROW_STRIDE;
        if (swp_q == LAST_CELL) begin
          swp_d   = LAST_ROW_START;
          state_d = ST_FILL;
        end else begin
          swp_d = swp_q + AW'(1);
        end
      end
      ST_FILL: begin
        // holds while the last copy word is written back
        if (!cp_v_q) begin
          if (swp_q == LAST_CELL) begin
            ld      = reply_q;
            ld_scr  = scr_q;
            state_d = ST_IDLE;
          end else begin
            swp_d = swp_q + AW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (ld) begin
      out_v_d    = 1'b1;
      out_pos_d  = POS_W'(pos);
      out_word_d = ld_word;
      out_scr_d  = ld_scr;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BACK: back_d = cfg_data_i;
        CFG_FORE: fore_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;       // clearing pass straight out of reset
      row_q      <= '0;
      col_q      <= '0;
      back_q     <= BACK_RESET;
      fore_q     <= FORE_RESET;
      swp_q      <= '0;
      fill_val_q <= RESET_CELL;
      reply_q    <= 1'b0;
      scr_q      <= 1'b0;
      cp_v_q     <= 1'b0;
      cp_dst_q   <= '0;
      rd_oob_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_pos_q  <= '0;
      out_word_q <= '0;
      out_scr_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      col_q      <= col_d;
      back_q     <= back_d;
      fore_q     <= fore_d;
      swp_q      <= swp_d;
      fill_val_q <= fill_val_d;
      reply_q    <= reply_d;
      scr_q      <= scr_d;
      cp_v_q     <= cp_v_d;
      cp_dst_q   <= cp_dst_d;
      rd_oob_q   <= rd_oob_d;
      out_v_q    <= out_v_d;
      out_pos_q  <= out_pos_d;
      out_word_q <= out_word_d;
      out_scr_q  <= out_scr_d;
    end
  end

  // A scrolled word leaves the cursor on the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_scr_q) |-> (row_q == ROW_LAST))
    else $error("scrolled word but cursor not on bottom row");

  // Copy write-back always lands a row above the read it came from
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cp_v_q && (state_q == ST_COPY)) |-> (cp_dst_q < swp_q))
    else $error("scroll copy overtook its read");

  // Cursor back on screen whenever a new word may be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (row_q < ROW_OVER))
    else $error("cursor past last row while idle");

endmodule

`default_nettype wire

// ===== tb/tb_text_console_writer.sv =====
`timescale 1ns / 1ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = COLUMNS * ROWS;
  localparam int CLK_PERIOD = 8;
  localparam int TAB_STEP   = 4;
  // kind 3 is left unused by the block, it must change nothing
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int PHASES       = 5;
  localparam int PHASE_WORDS  = 110;
  localparam int IDLE_PERCENT = 36;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [WORD_W-1:0] cell_word;
    logic              scrolled;
  } result_t;

  // Shadow copy of the screen, cursor and colours; every accepted input word
  // is played against it and the result it should give is queued.
  class screen_tracker;
    logic [WORD_W-1:0]  cells [CELLS];
    int unsigned        cursor;
    logic [COLOR_W-1:0] back;
    logic [COLOR_W-1:0] fore;
    result_t            due_results [$];
    int unsigned        fails;

    function new();
      back  = BACK_RESET;
      fore  = FORE_RESET;
      fails = 0;
      clear_cells();
    endfunction

    function logic [7:0] attr();
      return {back, fore};
    endfunction

    function void clear_cells();
      for (int i = 0; i < CELLS; i++) cells[i] = {attr(), CH_NUL};
      cursor = 0;
    endfunction

    function void set_colour(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] val);
      if (idx == CFG_BACK) back = val;
      else if (idx == CFG_FORE) fore = val;
    endfunction

    // Returns 1 when the screen had to scroll up
    function bit put_char(logic [CHAR_W-1:0] c);
      if (c == CH_NEWLINE) begin
        cursor += COLUMNS - cursor % COLUMNS;
      end else if (c == CH_BACKSPACE) begin
        // clamped at the first cell
        if (cursor > 0) begin
          cursor--;
          cells[cursor] = {attr(), CH_SPACE};
        end
      end else if (c == CH_TAB) begin
        cursor = (cursor + TAB_STEP) & ~(TAB_STEP - 1);
      end else if (c == CH_RETURN) begin
        cursor = (cursor / COLUMNS) * COLUMNS;
      end else if (c >= CH_SPACE) begin
        if (cursor < CELLS) cells[cursor] = {attr(), c};
        cursor++;
      end
      // other controls below space: nothing at all
      if (cursor / COLUMNS > ROWS - 1) begin
        for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = {attr(), CH_SPACE};
        cursor -= COLUMNS;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] c,
                            logic [IDX_W-1:0] idx);
      result_t r;
      r = '0;
      case (kind)
        KIND_PUT:   r.scrolled = put_char(c);
        KIND_READ:  if (idx < CELLS) r.cell_word = cells[idx];
        KIND_CLEAR: clear_cells();
        default: ;
      endcase
      r.cursor_pos = cursor[POS_W-1:0];
      due_results.push_back(r);
    endfunction

    function void check_result(logic [POS_W-1:0] pos, logic [WORD_W-1:0] word, logic scr);
      result_t due;
      if (due_results.size() == 0) begin
        $error("result word with nothing awaited: cursor_pos %0d cell_word %h", pos, word);
        fails++;
        return;
      end
      due = due_results.pop_front();
      if (pos !== due.cursor_pos) begin
        $error("cursor_pos: expected %0d, actual %0d", due.cursor_pos, pos);
        fails++;
      end
      if (word !== due.cell_word) begin
        $error("cell_word: expected %h, actual %h", due.cell_word, word);
        fails++;
      end
      if (scr !== due.scrolled) begin
        $error("scrolled: expected %0b, actual %0b", due.scrolled, scr);
        fails++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COLOR_W-1:0] cfg_data;
  // no random idling on either side while this is set
  bit                 steady;
  screen_tracker      tracker;

  tcw_in_if  item_bus ();
  tcw_out_if result_bus ();

  text_console_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_bus),
    .result_o   (result_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Offer one input word, with random idle cycles ahead of it, and hold it
  // until the block takes it. Valid is left high on return so that
  // back-to-back words need no extra assignment in the same step.
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] c,
                           input logic [IDX_W-1:0] ix);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      item_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_bus.valid      <= 1'b1;
    item_bus.kind       <= k;
    item_bus.char_code  <= c;
    item_bus.cell_index <= ix;
    do @(posedge clk_i); while (!item_bus.ready);
    tracker.note_item(k, c, ix);
  endtask

  // Sender stops and waits until every awaited result word has come back.
  // It always waits on a clock edge, so valid is never lowered and raised in one step.
  task automatic hold_until_drained();
    item_bus.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.due_results.size() != 0);
  endtask

  // Only called while the block is idle
  task automatic set_colours(input logic [COLOR_W-1:0] b, input logic [COLOR_W-1:0] f);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_BACK;
    cfg_data <= b;
    @(posedge clk_i);
    tracker.set_colour(CFG_BACK, b);
    cfg_idx  <= CFG_FORE;
    cfg_data <= f;
    @(posedge clk_i);
    tracker.set_colour(CFG_FORE, f);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly running text with line controls, reads spread over the screen and
  // around the cursor, and the odd clear or unused kind. newline_share is in
  // thousandths; a high share walks the cursor down into scrolling quickly.
  task automatic send_random(input int unsigned newline_share);
    int unsigned        roll;
    int unsigned        lo;
    logic [KIND_W-1:0]  k;
    logic [CHAR_W-1:0]  c;
    logic [IDX_W-1:0]   ix;
    roll = $urandom_range(999);
    k    = KIND_PUT;
    c    = CHAR_W'($urandom_range(255));
    ix   = IDX_W'($urandom_range(2 ** IDX_W - 1));
    if (roll < 5) begin
      k = KIND_CLEAR;
    end else if (roll < 20) begin
      k = KIND_SPARE;
    end else if (roll < 190) begin
      k = KIND_READ;
      case ($urandom_range(2))
        0: ;  // whole index range, past the screen too
        1: ix = IDX_W'($urandom_range(CELLS - 1));
        default: begin
          // just behind the cursor, where the fresh writes are
          lo = (tracker.cursor > 40) ? tracker.cursor - 40 : 0;
          ix = IDX_W'($urandom_range(tracker.cursor, lo));
        end
      endcase
    end else if (roll < 190 + newline_share) begin
      c = CH_NEWLINE;
    end else begin
      roll = $urandom_range(99);
      if (roll < 5) c = CH_TAB;
      else if (roll < 9) c = CH_RETURN;
      else if (roll < 16) c = CH_BACKSPACE;
      else if (roll < 20) c = CHAR_W'($urandom_range(CH_SPACE - 1));
      else c = CHAR_W'($urandom_range(255, CH_SPACE));
    end
    send_item(k, c, ix);
  endtask

  // Result side: check every accepted word, then pick ready for the next cycle
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_bus.valid && result_bus.ready)
        tracker.check_result(result_bus.cursor_pos, result_bus.cell_word,
                             result_bus.scrolled);
      result_bus.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  initial begin
    logic [COLOR_W-1:0] back_set [PHASES];
    logic [COLOR_W-1:0] fore_set [PHASES];
    tracker = new();
    steady  = 1'b0;
    item_bus.valid      <= 1'b0;
    item_bus.kind       <= KIND_PUT;
    item_bus.char_code  <= CH_NUL;
    item_bus.cell_index <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_BACK;
    cfg_data <= '0;
    rst_ni   <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the reset colours. Ready stays low through the
    // clearing pass after reset, so the first word simply waits.
    send_item(KIND_READ,  8'hFF,        11'd0);     // cell left by reset
    send_item(KIND_READ,  CH_NUL,       11'd1999);  // last cell
    send_item(KIND_READ,  8'hAA,        11'd2000);  // just past the screen
    send_item(KIND_READ,  8'h55,        11'd2047);  // top of the index range
    send_item(KIND_SPARE, 8'hFF,        11'd2047);  // unused kind
    send_item(KIND_PUT,   CH_BACKSPACE, 11'd0);     // backspace on the first cell
    send_item(KIND_PUT,   CH_NUL,       11'd0);     // control that does nothing
    send_item(KIND_PUT,   8'h1F,        11'd1365);
    send_item(KIND_PUT,   CH_SPACE,     11'd0);
    send_item(KIND_PUT,   8'h41,        11'd0);
    send_item(KIND_PUT,   8'hFF,        11'd0);
    send_item(KIND_PUT,   8'h7F,        11'd0);
    send_item(KIND_PUT,   CH_TAB,       11'd0);     // 4 -> 8
    send_item(KIND_PUT,   CH_TAB,       11'd0);     // aligned, still a full step
    send_item(KIND_PUT,   CH_RETURN,    11'd0);
    send_item(KIND_PUT,   CH_NEWLINE,   11'd0);
    send_item(KIND_PUT,   CH_BACKSPACE, 11'd0);     // back onto the row above
    send_item(KIND_READ,  CH_NUL,       11'd79);
    send_item(KIND_READ,  CH_NUL,       11'd3);
    send_item(KIND_CLEAR, 8'h3C,        11'd682);
    send_item(KIND_READ,  CH_NUL,       11'd0);
    hold_until_drained();

    // Colour settings per phase: the extremes, then random pairs
    back_set = '{4'hF, 4'h0, 4'hF, 4'h0, 4'h0};
    fore_set = '{4'h0, 4'h0, 4'hF, 4'h0, 4'h0};
    for (int p = 3; p < PHASES; p++) begin
      back_set[p] = COLOR_W'($urandom_range(15));
      fore_set[p] = COLOR_W'($urandom_range(15));
    end

    for (int p = 0; p < PHASES; p++) begin
      set_colours(back_set[p], fore_set[p]);
      steady = (p == 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_random((p == 2) ? 400 : 100);
        // sender holds off mid-phase until everything is back
        if (p == 0 && n == PHASE_WORDS / 2) hold_until_drained();
      end
      hold_until_drained();
    end
    steady = 1'b0;

    // a stray word could still follow a full screen pass
    repeat (CELLS + 8) @(posedge clk_i);
    if (tracker.fails == 0) begin
      $display("text_console_writer: match");
    end else begin
      $display("text_console_writer: mismatch");
    end
    $finish;
  end

  // Watchdog, far beyond a run made of nothing but clears and scrolls
  initial begin
    #(64'd50_000_000);
    $display("text_console_writer: mismatch");
    $finish;
  end

endmodule
